// ===== rtl/rps_pkg.sv =====
// Shared constants, codes and control structures of the roulette parent selector
package rps_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int KEY_BITS_DEF      = 16;
    localparam int FITNESS_BITS_DEF  = 16;
    localparam int DRAW_BITS_DEF     = 15;

    localparam int          REDRAW_LIMIT = 64;
    localparam int          TRY_W        = $clog2(REDRAW_LIMIT);
    localparam logic [31:0] LFSR_TAPS    = 32'h8020_0003;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_SELECT = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_FEW  = 2'd3;

    localparam logic [2:0] RD_IDX    = 3'd0;
    localparam logic [2:0] RD_PREV   = 3'd1;
    localparam logic [2:0] RD_NEXT   = 3'd2;
    localparam logic [2:0] RD_MOTHER = 3'd3;
    localparam logic [2:0] RD_FATHER = 3'd4;

    localparam logic WR_NEW  = 1'b0;
    localparam logic WR_MOVE = 1'b1;

    typedef struct packed {
        logic       cap;
        logic       idx_clr;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_load_count;
        logic       idx_load_pos;
        logic [2:0] rd_sel;
        logic       ram_we;
        logic       wr_sel;
        logic       find_ev;
        logic       sum_acc;
        logic       draw;
        logic       spin_ev;
        logic       set_mother;
        logic       set_father;
        logic       try_inc;
        logic       fb_ev;
        logic       count_inc;
        logic       count_dec;
        logic       set_status;
        logic [1:0] status_val;
        logic       load_mkey;
        logic       load_fkey;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op_in;
        logic [1:0] op;
        logic       idx_at_count;
        logic       idx_is_pos;
        logic       idx_last;
        logic       hit;
        logic       found;
        logic       full;
        logic       few;
        logic       spin_hit;
        logic       father_phase;
        logic       pick_differs;
        logic       tries_last;
        logic       fb_ok;
    } stat_t;

endpackage

// ===== rtl/roulette_parent_selector.sv =====
// Top level of the roulette parent selector: controller joined to datapath
//
// Usage: raise start with operation, key and fitness while busy is low; the
// word is taken at that edge and busy rises on the next cycle. Operations:
// add, remove, update fitness, select two parents. When the work is finished
// done pulses for exactly one cycle with status, mother_key and father_key;
// the receiver cannot stall and must take the word in that cycle.
// Steps: add, remove and update run a search pass over the entries that
// stops at the key, then for add or remove a shift pass through the table
// RAM that reads and then writes each entry moved. Select runs a sum pass
// over the fitness values (and ends there when fewer than two entries are
// positive), then roulette draws that each scan the entries up to the one
// they land on, with up to 65 draws and a fallback scan of the entries, then
// fetches the keys. One word is worked on at a time.
// random_seed_wr_en loads random_seed into the LFSR (zero loads as one);
// write it only while idle.
// Reset empties the table and loads the LFSR with one; table contents need
// no clearing since only entries below the count are read.
module roulette_parent_selector #(
    parameter int TABLE_ENTRIES = rps_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = rps_pkg::KEY_BITS_DEF,
    parameter int FITNESS_BITS  = rps_pkg::FITNESS_BITS_DEF,
    parameter int DRAW_BITS     = rps_pkg::DRAW_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [FITNESS_BITS-1:0] fitness,
    input  logic                    random_seed_wr_en,
    input  logic [31:0]             random_seed,
    output logic                    done,
    output logic [1:0]              status,
    output logic [KEY_BITS-1:0]     mother_key,
    output logic [KEY_BITS-1:0]     father_key
);

    rps_pkg::cmd_t  cmd;
    rps_pkg::stat_t st;

    rps_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .st   (st),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    rps_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BITS     (KEY_BITS),
        .FITNESS_BITS (FITNESS_BITS),
        .DRAW_BITS    (DRAW_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .operation        (operation),
        .key              (key),
        .fitness          (fitness),
        .random_seed_wr_en(random_seed_wr_en),
        .random_seed      (random_seed),
        .status           (status),
        .mother_key       (mother_key),
        .father_key       (father_key)
    );

endmodule

// ===== rtl/rps_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module rps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rps_ctrl.sv =====
// Controller state machine sequencing table edits and roulette draws
module rps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rps_pkg::stat_t st,
    output rps_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           done
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_FIND_RD = 5'd1;
    localparam logic [4:0] S_FIND_EV = 5'd2;
    localparam logic [4:0] S_DECIDE  = 5'd3;
    localparam logic [4:0] S_SHUP_RD = 5'd4;
    localparam logic [4:0] S_SHUP_WR = 5'd5;
    localparam logic [4:0] S_SHDN_RD = 5'd6;
    localparam logic [4:0] S_SHDN_WR = 5'd7;
    localparam logic [4:0] S_SUM_RD  = 5'd8;
    localparam logic [4:0] S_SUM_EV  = 5'd9;
    localparam logic [4:0] S_SUM_END = 5'd10;
    localparam logic [4:0] S_DRAW    = 5'd11;
    localparam logic [4:0] S_SPIN_RD = 5'd12;
    localparam logic [4:0] S_SPIN_EV = 5'd13;
    localparam logic [4:0] S_PICKED  = 5'd14;
    localparam logic [4:0] S_FB_RD   = 5'd15;
    localparam logic [4:0] S_FB_EV   = 5'd16;
    localparam logic [4:0] S_KEYM    = 5'd17;
    localparam logic [4:0] S_KEYF    = 5'd18;
    localparam logic [4:0] S_KEYW    = 5'd19;
    localparam logic [4:0] S_DONE    = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap = 1'b1;
                    if (st.op_in == rps_pkg::OP_SELECT)
                    begin
                        state_next = S_SUM_RD;
                    end
                    else
                    begin
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD:
            begin
                cmd.rd_sel = rps_pkg::RD_IDX;
                if (st.idx_at_count)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_FIND_EV;
                end
            end
            S_FIND_EV:
            begin
                cmd.find_ev = 1'b1;
                if (st.hit)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_DECIDE:
            begin
                case (st.op)
                    rps_pkg::OP_ADD:
                    begin
                        if (st.found)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = rps_pkg::ST_KEY;
                            state_next     = S_DONE;
                        end
                        else if (st.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = rps_pkg::ST_FULL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = S_SHUP_RD;
                        end
                    end
                    rps_pkg::OP_REMOVE:
                    begin
                        if (st.found)
                        begin
                            cmd.idx_load_pos = 1'b1;
                            state_next       = S_SHDN_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        if (st.found)
                        begin
                            cmd.ram_we = 1'b1;
                            cmd.wr_sel = rps_pkg::WR_NEW;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = rps_pkg::ST_KEY;
                        end
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SHUP_RD:
            begin
                if (st.idx_is_pos)
                begin
                    cmd.ram_we    = 1'b1;
                    cmd.wr_sel    = rps_pkg::WR_NEW;
                    cmd.count_inc = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = rps_pkg::RD_PREV;
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.wr_sel  = rps_pkg::WR_MOVE;
                cmd.idx_dec = 1'b1;
                state_next  = S_SHUP_RD;
            end
            S_SHDN_RD:
            begin
                if (st.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = rps_pkg::RD_NEXT;
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.wr_sel  = rps_pkg::WR_MOVE;
                cmd.idx_inc = 1'b1;
                state_next  = S_SHDN_RD;
            end
            S_SUM_RD:
            begin
                cmd.rd_sel = rps_pkg::RD_IDX;
                if (st.idx_at_count)
                begin
                    state_next = S_SUM_END;
                end
                else
                begin
                    state_next = S_SUM_EV;
                end
            end
            S_SUM_EV:
            begin
                cmd.sum_acc = 1'b1;
                state_next  = S_SUM_RD;
            end
            S_SUM_END:
            begin
                if (st.few)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = rps_pkg::ST_FEW;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                cmd.draw    = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_SPIN_RD;
            end
            S_SPIN_RD:
            begin
                cmd.rd_sel = rps_pkg::RD_IDX;
                state_next = S_SPIN_EV;
            end
            S_SPIN_EV:
            begin
                cmd.spin_ev = 1'b1;
                if (st.spin_hit)
                begin
                    state_next = S_PICKED;
                end
                else
                begin
                    state_next = S_SPIN_RD;
                end
            end
            S_PICKED:
            begin
                if (!st.father_phase)
                begin
                    cmd.set_mother = 1'b1;
                    state_next     = S_DRAW;
                end
                else if (st.pick_differs)
                begin
                    cmd.set_father = 1'b1;
                    state_next     = S_KEYM;
                end
                else if (st.tries_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_FB_RD;
                end
                else
                begin
                    cmd.try_inc = 1'b1;
                    state_next  = S_DRAW;
                end
            end
            S_FB_RD:
            begin
                cmd.rd_sel = rps_pkg::RD_IDX;
                state_next = S_FB_EV;
            end
            S_FB_EV:
            begin
                cmd.fb_ev = 1'b1;
                if (st.fb_ok)
                begin
                    state_next = S_KEYM;
                end
                else
                begin
                    state_next = S_FB_RD;
                end
            end
            S_KEYM:
            begin
                cmd.rd_sel = rps_pkg::RD_MOTHER;
                state_next = S_KEYF;
            end
            S_KEYF:
            begin
                cmd.load_mkey = 1'b1;
                cmd.rd_sel    = rps_pkg::RD_FATHER;
                state_next    = S_KEYW;
            end
            S_KEYW:
            begin
                cmd.load_fkey = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rps_datapath.sv =====
// Datapath: entry table, counters, fitness sum, LFSR and roulette arithmetic
module rps_datapath #(
    parameter int TABLE_ENTRIES = rps_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = rps_pkg::KEY_BITS_DEF,
    parameter int FITNESS_BITS  = rps_pkg::FITNESS_BITS_DEF,
    parameter int DRAW_BITS     = rps_pkg::DRAW_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rps_pkg::cmd_t           cmd,
    output rps_pkg::stat_t          st,
    input  logic [1:0]              operation,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [FITNESS_BITS-1:0] fitness,
    input  logic                    random_seed_wr_en,
    input  logic [31:0]             random_seed,
    output logic [1:0]              status,
    output logic [KEY_BITS-1:0]     mother_key,
    output logic [KEY_BITS-1:0]     father_key
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int TW = FITNESS_BITS + CW;
    localparam int PW = TW + DRAW_BITS;
    localparam int EW = KEY_BITS + FITNESS_BITS;

    logic [1:0]              op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [FITNESS_BITS-1:0] fit_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           pos_reg;
    logic                    found_reg;
    logic [TW-1:0]           total_reg;
    logic [1:0]              poscnt_reg;
    logic [TW-1:0]           choice_reg;
    logic [31:0]             lfsr_reg;
    logic [IW-1:0]           pick_reg;
    logic [IW-1:0]           m_reg;
    logic [IW-1:0]           f_reg;
    logic                    phase_reg;
    logic [rps_pkg::TRY_W-1:0] tries_reg;
    logic [1:0]              status_reg;
    logic [KEY_BITS-1:0]     mkey_reg;
    logic [KEY_BITS-1:0]     fkey_reg;

    logic [EW-1:0]           rdata;
    logic [EW-1:0]           wdata;
    logic [IW-1:0]           raddr;
    logic [IW-1:0]           waddr;
    logic [KEY_BITS-1:0]     rkey;
    logic [FITNESS_BITS-1:0] rfit;
    logic [CW:0]             idx_plus;
    logic [CW-1:0]           idx_prev;
    logic [31:0]             lfsr_next;
    logic [PW-1:0]           product;

    assign rkey     = rdata[EW-1:FITNESS_BITS];
    assign rfit     = rdata[FITNESS_BITS-1:0];
    assign idx_plus = {1'b0, idx_reg} + {{CW{1'b0}}, 1'b1};
    assign idx_prev = idx_reg - {{(CW-1){1'b0}}, 1'b1};

    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? rps_pkg::LFSR_TAPS : 32'd0);
    assign product   = {{DRAW_BITS{1'b0}}, total_reg} *
                       {{TW{1'b0}}, lfsr_next[DRAW_BITS-1:0]};

    always_comb
    begin
        case (cmd.rd_sel)
            rps_pkg::RD_IDX:    raddr = idx_reg[IW-1:0];
            rps_pkg::RD_PREV:   raddr = idx_prev[IW-1:0];
            rps_pkg::RD_NEXT:   raddr = idx_plus[IW-1:0];
            rps_pkg::RD_MOTHER: raddr = m_reg;
            rps_pkg::RD_FATHER: raddr = f_reg;
            default:            raddr = idx_reg[IW-1:0];
        endcase
    end

    assign waddr = (cmd.wr_sel == rps_pkg::WR_MOVE) ? idx_reg[IW-1:0] : pos_reg[IW-1:0];
    assign wdata = (cmd.wr_sel == rps_pkg::WR_MOVE) ? rdata : {key_reg, fit_reg};

    rps_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (cmd.ram_we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign st.op_in        = operation;
    assign st.op           = op_reg;
    assign st.idx_at_count = (idx_reg == count_reg);
    assign st.idx_is_pos   = (idx_reg == pos_reg);
    assign st.idx_last     = (idx_plus >= {1'b0, count_reg});
    assign st.hit          = (rkey == key_reg);
    assign st.found        = found_reg;
    assign st.full         = (count_reg == CW'(TABLE_ENTRIES));
    assign st.few          = (poscnt_reg < 2'd2);
    assign st.spin_hit     = (choice_reg < {{CW{1'b0}}, rfit});
    assign st.father_phase = phase_reg;
    assign st.pick_differs = (pick_reg != m_reg);
    assign st.tries_last   = (tries_reg == rps_pkg::TRY_W'(rps_pkg::REDRAW_LIMIT - 1));
    assign st.fb_ok        = (idx_reg[IW-1:0] != m_reg) && (rfit != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            lfsr_reg   <= 32'd1;
            idx_reg    <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            phase_reg  <= 1'b0;
            tries_reg  <= '0;
            poscnt_reg <= '0;
            status_reg <= rps_pkg::ST_OK;
        end
        else
        begin
            if (random_seed_wr_en)
            begin
                lfsr_reg <= (random_seed == 32'd0) ? 32'd1 : random_seed;
            end
            if (cmd.cap)
            begin
                op_reg     <= operation;
                key_reg    <= key;
                fit_reg    <= fitness;
                idx_reg    <= '0;
                pos_reg    <= '0;
                found_reg  <= 1'b0;
                total_reg  <= '0;
                poscnt_reg <= '0;
                phase_reg  <= 1'b0;
                tries_reg  <= '0;
                status_reg <= rps_pkg::ST_OK;
                mkey_reg   <= '0;
                fkey_reg   <= '0;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus[CW-1:0];
            end
            if (cmd.idx_dec)
            begin
                idx_reg <= idx_prev;
            end
            if (cmd.idx_load_count)
            begin
                idx_reg <= count_reg;
            end
            if (cmd.idx_load_pos)
            begin
                idx_reg <= pos_reg;
            end
            if (cmd.find_ev)
            begin
                if (rkey == key_reg)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    if (rkey < key_reg)
                    begin
                        pos_reg <= pos_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                    idx_reg <= idx_plus[CW-1:0];
                end
            end
            if (cmd.sum_acc)
            begin
                total_reg <= total_reg + {{CW{1'b0}}, rfit};
                if ((rfit != '0) && (poscnt_reg != 2'd2))
                begin
                    poscnt_reg <= poscnt_reg + 2'd1;
                end
                idx_reg <= idx_plus[CW-1:0];
            end
            if (cmd.draw)
            begin
                lfsr_reg   <= lfsr_next;
                choice_reg <= product[PW-1:DRAW_BITS];
            end
            if (cmd.spin_ev)
            begin
                if (choice_reg < {{CW{1'b0}}, rfit})
                begin
                    pick_reg <= idx_reg[IW-1:0];
                end
                else
                begin
                    choice_reg <= choice_reg - {{CW{1'b0}}, rfit};
                    idx_reg    <= idx_plus[CW-1:0];
                end
            end
            if (cmd.set_mother)
            begin
                m_reg     <= pick_reg;
                phase_reg <= 1'b1;
                tries_reg <= '0;
            end
            if (cmd.set_father)
            begin
                f_reg <= pick_reg;
            end
            if (cmd.try_inc)
            begin
                tries_reg <= tries_reg + {{(rps_pkg::TRY_W-1){1'b0}}, 1'b1};
            end
            if (cmd.fb_ev)
            begin
                if (st.fb_ok)
                begin
                    f_reg <= idx_reg[IW-1:0];
                end
                else
                begin
                    idx_reg <= idx_plus[CW-1:0];
                end
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            if (cmd.count_dec)
            begin
                count_reg <= count_reg - {{(CW-1){1'b0}}, 1'b1};
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_val;
            end
            if (cmd.load_mkey)
            begin
                mkey_reg <= rkey;
            end
            if (cmd.load_fkey)
            begin
                fkey_reg <= rkey;
            end
        end
    end

    assign status     = status_reg;
    assign mother_key = mkey_reg;
    assign father_key = fkey_reg;

endmodule

// ===== sim/tb_roulette_parent_selector.sv =====
// Testbench of the roulette parent selector: directed and random table traffic checked against a predictor
`timescale 1ns / 1ps

module tb_roulette_parent_selector;

    localparam int  TABLE_SIZE  = 32;
    localparam int  DRAW_W      = 15;
    localparam int  MAX_CYCLES  = 40000000;
    localparam int  PHASE_ITEMS = 350;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] key;
        logic [15:0] fit;
    } word_t;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] mother;
        logic [15:0] father;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = rps_pkg::OP_ADD;
    logic [15:0] key = '0;
    logic [15:0] fitness = '0;
    logic        random_seed_wr_en = 1'b0;
    logic [31:0] random_seed = 32'd1;
    logic        done;
    logic [1:0]  status;
    logic [15:0] mother_key;
    logic [15:0] father_key;

    word_t       pending_words[$];
    verdict_t    awaited_verdicts[$];
    logic [15:0] key_pool[40];
    int          errors = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    bit          calm = 1'b0;
    bit          took;
    bit          start_next;
    word_t       next_word;

    // predictor state
    logic [15:0] tab_key[TABLE_SIZE];
    logic [15:0] tab_fit[TABLE_SIZE];
    int          tab_count = 0;
    logic [31:0] lfsr = 32'd1;

    roulette_parent_selector dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .key               (key),
        .fitness           (fitness),
        .random_seed_wr_en (random_seed_wr_en),
        .random_seed       (random_seed),
        .done              (done),
        .status            (status),
        .mother_key        (mother_key),
        .father_key        (father_key)
    );

    always #4 clk = ~clk;

    function automatic int find_slot(logic [15:0] k);
        for (int i = 0; i < tab_count; i++)
        begin
            if (tab_key[i] == k)
                return i;
        end
        return tab_count;
    endfunction

    function automatic int spin_wheel(longint unsigned total);
        longint unsigned r;
        longint unsigned choice;
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ rps_pkg::LFSR_TAPS) : (lfsr >> 1);
        r = lfsr[DRAW_W-1:0];
        choice = (total >> DRAW_W) * r + (((total & 32'h7FFF) * r) >> DRAW_W);
        for (int i = 0; i < tab_count; i++)
        begin
            if (choice < tab_fit[i])
                return i;
            choice -= tab_fit[i];
        end
        return tab_count - 1;
    endfunction

    function automatic verdict_t apply_word(word_t w);
        verdict_t        v;
        int              pos;
        int              positive;
        int              m;
        int              f;
        bit              found;
        longint unsigned total;
        v = '{rps_pkg::ST_OK, 16'd0, 16'd0};
        case (w.op)
            rps_pkg::OP_ADD:
            begin
                if (find_slot(w.key) < tab_count)
                    v.status = rps_pkg::ST_KEY;
                else if (tab_count >= TABLE_SIZE)
                    v.status = rps_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < tab_count && tab_key[pos] < w.key)
                        pos++;
                    for (int i = tab_count; i > pos; i--)
                    begin
                        tab_key[i] = tab_key[i-1];
                        tab_fit[i] = tab_fit[i-1];
                    end
                    tab_key[pos] = w.key;
                    tab_fit[pos] = w.fit;
                    tab_count++;
                end
            end
            rps_pkg::OP_REMOVE:
            begin
                pos = find_slot(w.key);
                if (pos < tab_count)
                begin
                    for (int i = pos; i + 1 < tab_count; i++)
                    begin
                        tab_key[i] = tab_key[i+1];
                        tab_fit[i] = tab_fit[i+1];
                    end
                    tab_count--;
                end
            end
            rps_pkg::OP_UPDATE:
            begin
                pos = find_slot(w.key);
                if (pos < tab_count)
                    tab_fit[pos] = w.fit;
                else
                    v.status = rps_pkg::ST_KEY;
            end
            default:
            begin
                total = 0;
                positive = 0;
                for (int i = 0; i < tab_count; i++)
                begin
                    total += tab_fit[i];
                    if (tab_fit[i] != 0)
                        positive++;
                end
                if (positive < 2)
                    v.status = rps_pkg::ST_FEW;
                else
                begin
                    found = 1'b0;
                    f = 0;
                    m = spin_wheel(total);
                    for (int t = 0; t < rps_pkg::REDRAW_LIMIT && !found; t++)
                    begin
                        f = spin_wheel(total);
                        found = (f != m);
                    end
                    for (int i = 0; i < tab_count && !found; i++)
                    begin
                        if (i != m && tab_fit[i] != 0)
                        begin
                            f = i;
                            found = 1'b1;
                        end
                    end
                    v.mother = tab_key[m];
                    v.father = tab_key[f];
                end
            end
        endcase
        return v;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int    pick;
        pick = $urandom_range(0, 99);
        w.op = pick < 35 ? rps_pkg::OP_ADD : pick < 50 ? rps_pkg::OP_REMOVE :
               pick < 65 ? rps_pkg::OP_UPDATE : rps_pkg::OP_SELECT;
        w.key = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, 39)]
                                             : 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        w.fit = pick < 10 ? 16'd0 : pick < 20 ? 16'hFFFF :
                pick < 50 ? 16'($urandom_range(1, 255)) : 16'($urandom_range(0, 65535));
        return w;
    endfunction

    // driver: hold start until the word is taken, then fetch the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                awaited_verdicts.push_back(apply_word('{operation, key, fitness}));
            start_next = start && !took;
            if (!start_next && !took)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    operation <= next_word.op;
                    key       <= next_word.key;
                    fitness   <= next_word.fit;
                    start_next = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= calm ? 0 : $urandom_range(0, 9);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            start <= start_next;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_verdicts.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d mother=%h father=%h",
                         $time, status, mother_key, father_key);
                errors++;
            end
            else
            begin
                verdict_t v;
                v = awaited_verdicts.pop_front();
                if (status !== v.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, v.status, status);
                    errors++;
                end
                if (mother_key !== v.mother)
                begin
                    $display("%0t: mother_key expected %h actual %h", $time, v.mother, mother_key);
                    errors++;
                end
                if (father_key !== v.father)
                begin
                    $display("%0t: father_key expected %h actual %h", $time, v.father, father_key);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic drain();
        while (pending_words.size() != 0 || start || busy || awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_seed(logic [31:0] s);
        @(posedge clk);
        random_seed_wr_en <= 1'b1;
        random_seed       <= s;
        lfsr = (s == 0) ? 32'd1 : s;
        @(posedge clk);
        random_seed_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] seeds[5];
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 40; i++)
            key_pool[i] = 16'($urandom_range(0, 65535));
        seeds = '{32'hFFFF_FFFF, 32'd0, $urandom(), 32'd1, $urandom()};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_ADD,    16'h0000, 16'hFFFF});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_ADD,    16'hFFFF, 16'h0001});
        pending_words.push_back('{rps_pkg::OP_ADD,    16'h0000, 16'h1234});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_UPDATE, 16'h0005, 16'h0007});
        pending_words.push_back('{rps_pkg::OP_UPDATE, 16'hFFFF, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_REMOVE, 16'h0007, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_REMOVE, 16'hFFFF, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_ADD,    16'h5555, 16'hAAAA});
        pending_words.push_back('{rps_pkg::OP_ADD,    16'hAAAA, 16'h5555});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'hFFFF, 16'hFFFF});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_UPDATE, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_SELECT, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_REMOVE, 16'h0000, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_REMOVE, 16'h5555, 16'h0000});
        pending_words.push_back('{rps_pkg::OP_REMOVE, 16'hAAAA, 16'h0000});
        drain();

        foreach (seeds[p])
        begin
            load_seed(seeds[p]);
            calm = p[0];
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_words.push_back(random_word());
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
